// ----- rtl/core/mbab_pkg.sv -----
package mbab_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [14:0] byte_addr;
        logic [7:0]  wr_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       done_res;
    } t_out_word;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_BLIT  = 2'd2;

    localparam logic [2:0] REG_DST_LEFT   = 3'd0;
    localparam logic [2:0] REG_DST_RIGHT  = 3'd1;
    localparam logic [2:0] REG_DST_TOP    = 3'd2;
    localparam logic [2:0] REG_DST_BOTTOM = 3'd3;
    localparam logic [2:0] REG_SRC_COL    = 3'd4;
    localparam logic [2:0] REG_SRC_ROW    = 3'd5;
    localparam logic [2:0] REG_INVERT     = 3'd6;

    localparam int CFG_W = 10;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD0   = 8'b0000_0010,
        ST_RD1   = 8'b0000_0100,
        ST_RDD   = 8'b0000_1000,
        ST_WR    = 8'b0001_0000,
        ST_NEXT  = 8'b0010_0000,
        ST_HOST  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/core/mono_bitmap_aligned_blit.sv -----
// channel | valid         | stall         | payload
// in      | i_in_valid    | o_in_stall    | i_in_word  (action, byte_addr, wr_data)
// out     | o_out_valid   | i_out_stall   | o_out_word (rd_data, done_res)
// cfg     | i_cfg_we      | -             | i_cfg_index, i_cfg_data
// Host write, empty blit, unused action: ST_OUT after accept. Read: ST_HOST, ST_RDD,
// ST_OUT. Blit: ST_NEXT, ST_RD0, ST_RD1, ST_RDD, ST_WR per destination byte, then
// ST_OUT; the single store port serves two source reads, dest read and write in turn.
// Reset is synchronous and active low; the frame store is not cleared.
// The input stalls while a word is at work or its result waits on the output.
module mono_bitmap_aligned_blit #(
    parameter int ROW_BYTES = 64,
    parameter int ROWS      = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mbab_pkg::t_in_word     i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mbab_pkg::t_out_word    o_out_word,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [mbab_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int DEPTH = ROW_BYTES * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = 24;

    logic [9:0] r_dl, r_dr, r_dt, r_db;
    logic [8:0] r_sc, r_sr;
    logic       r_inv;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;
    logic       r_q_ok;

    mbab_pkg::t_state r_st;
    logic             r_out_v;
    logic [7:0]       r_out_d;
    logic             r_blit_q;

    logic signed [LW-1:0] r_dwx, r_swx, r_dwx2, r_dy, r_sy, r_dy1, r_sy1, r_dy2;
    logic                 r_xinc, r_yinc;
    logic [2:0]           r_shift;
    logic [7:0]           r_s0, r_s1, r_smask;
    logic signed [LW-1:0] r_addr;
    logic                 r_addr_ok;
    logic [7:0]           r_wdata;
    logic                 r_we;

    logic signed [LW-1:0] w_dl, w_dr, w_sl, w_sr;
    logic signed [LW-1:0] w_da, w_sa;
    logic [7:0]           w_xm, w_m1, w_m2, w_bits, w_q;
    logic [15:0]          w_pair;
    logic signed [LW-1:0] w_off, w_hi;
    logic                 w_accept;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_st != mbab_pkg::ST_IDLE) || r_out_v;
    assign o_out_valid = r_out_v;
    assign o_out_word = '{rd_data: r_out_d, done_res: 1'b1};

    assign w_dl = LW'(r_dl);
    assign w_dr = LW'(r_dr) - LW'(1);
    assign w_sl = LW'(r_sc);
    assign w_sr = w_sl + w_dr - w_dl;
    assign w_xm = r_inv ? 8'hFF : 8'h00;
    assign w_da = r_dy * LW'(ROW_BYTES) + (r_dwx >>> 3);
    assign w_sa = r_sy * LW'(ROW_BYTES) + (r_swx >>> 3);

    function automatic logic signed [LW-1:0] f_floor8(input logic signed [LW-1:0] v);
        f_floor8 = {v[LW-1:3], 3'b000};
    endfunction

    // edge masks for the current destination byte column
    always_comb begin
        w_off = w_dl - r_dwx;
        w_hi  = w_dr - r_dwx + LW'(1);
        w_m1  = 8'hFF;
        w_m2  = 8'hFF;
        if (r_dwx < w_dl) w_m1 = 8'((9'd1 << (4'd8 - 4'(w_off))) - 9'd1);
        if (r_dwx + LW'(7) > w_dr) w_m2 = ~8'((9'd1 << (4'd8 - 4'(w_hi))) - 9'd1);
    end

    assign w_q    = r_q_ok ? r_q : 8'h00;
    assign w_pair = {r_s0, r_s1};
    assign w_bits = (r_shift == 3'd0) ? r_s0 : 8'(w_pair >> r_shift);

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_addr[AW-1:0]] <= r_wdata;
        r_q    <= r_mem[r_addr[AW-1:0]];
        r_q_ok <= r_addr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl <= '0; r_dr <= '0; r_dt <= '0; r_db <= '0;
            r_sc <= '0; r_sr <= '0; r_inv <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbab_pkg::REG_DST_LEFT:   r_dl  <= i_cfg_data;
                mbab_pkg::REG_DST_RIGHT:  r_dr  <= i_cfg_data;
                mbab_pkg::REG_DST_TOP:    r_dt  <= i_cfg_data;
                mbab_pkg::REG_DST_BOTTOM: r_db  <= i_cfg_data;
                mbab_pkg::REG_SRC_COL:    r_sc  <= i_cfg_data[8:0];
                mbab_pkg::REG_SRC_ROW:    r_sr  <= i_cfg_data[8:0];
                mbab_pkg::REG_INVERT:     r_inv <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
        end else begin
            r_we <= (w_accept && i_in_word.action == mbab_pkg::ACT_WRITE
                     && 32'(i_in_word.byte_addr) < 32'(DEPTH))
                 || (r_st == mbab_pkg::ST_WR && r_addr_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= mbab_pkg::ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= (r_st == mbab_pkg::ST_OUT) || (r_out_v && i_out_stall);
            unique case (r_st)
                mbab_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_out_d   <= 8'h00;
                        r_addr    <= LW'(i_in_word.byte_addr);
                        r_addr_ok <= 32'(i_in_word.byte_addr) < 32'(DEPTH);
                        unique case (i_in_word.action)
                            mbab_pkg::ACT_WRITE: begin
                                r_wdata <= i_in_word.wr_data;
                                r_st    <= mbab_pkg::ST_OUT;
                            end
                            mbab_pkg::ACT_READ: r_st <= mbab_pkg::ST_HOST;
                            mbab_pkg::ACT_BLIT: begin
                                if (r_dr <= r_dl || r_db <= r_dt) begin
                                    r_st <= mbab_pkg::ST_OUT;
                                end else begin
                                    r_shift <= 3'(w_dl - w_sl);
                                    if (r_dt <= 10'(r_sr)) begin
                                        r_dy1 <= LW'(r_dt); r_dy <= LW'(r_dt);
                                        r_dy2 <= LW'(r_db) - LW'(1);
                                        r_sy1 <= LW'(r_sr); r_sy <= LW'(r_sr);
                                        r_yinc <= 1'b1;
                                    end else begin
                                        r_dy1 <= LW'(r_db) - LW'(1);
                                        r_dy  <= LW'(r_db) - LW'(1);
                                        r_dy2 <= LW'(r_dt);
                                        r_sy1 <= LW'(r_sr) + LW'(r_db) - LW'(1) - LW'(r_dt);
                                        r_sy  <= LW'(r_sr) + LW'(r_db) - LW'(1) - LW'(r_dt);
                                        r_yinc <= 1'b0;
                                    end
                                    if (w_dl <= w_sl) begin
                                        r_dwx  <= f_floor8(w_dl);
                                        r_swx  <= f_floor8(w_sl - LW'(r_dl[2:0]));
                                        r_dwx2 <= f_floor8(w_dr);
                                        r_xinc <= 1'b1;
                                    end else begin
                                        r_dwx  <= f_floor8(w_dr);
                                        r_swx  <= f_floor8(w_sr - (w_dr & LW'(7)));
                                        r_dwx2 <= f_floor8(w_dl);
                                        r_xinc <= 1'b0;
                                    end
                                    r_st <= mbab_pkg::ST_NEXT;
                                end
                            end
                            default: r_st <= mbab_pkg::ST_OUT;
                        endcase
                    end
                end
                mbab_pkg::ST_HOST: r_st <= mbab_pkg::ST_RDD;
                mbab_pkg::ST_NEXT: begin
                    r_smask   <= w_m1 & w_m2;
                    r_addr    <= w_sa;
                    r_addr_ok <= w_sa >= 0 && w_sa < LW'(DEPTH);
                    r_st      <= mbab_pkg::ST_RD0;
                end
                mbab_pkg::ST_RD0: begin
                    r_addr    <= r_addr + LW'(1);
                    r_addr_ok <= r_addr + LW'(1) >= 0 && r_addr + LW'(1) < LW'(DEPTH);
                    r_st      <= mbab_pkg::ST_RD1;
                end
                mbab_pkg::ST_RD1: begin
                    r_s0      <= w_q ^ w_xm;
                    r_addr    <= w_da;
                    r_addr_ok <= w_da >= 0 && w_da < LW'(DEPTH);
                    r_st      <= mbab_pkg::ST_RDD;
                end
                mbab_pkg::ST_RDD: begin
                    r_s1 <= w_q ^ w_xm;
                    if (r_blit_q) begin
                        r_st <= mbab_pkg::ST_WR;
                    end else begin
                        r_out_d <= w_q;
                        r_st    <= mbab_pkg::ST_OUT;
                    end
                end
                mbab_pkg::ST_WR: begin
                    r_wdata <= (w_q & ~r_smask) | (w_bits & r_smask);
                    if (r_dy == r_dy2) begin
                        if (r_dwx == r_dwx2) begin
                            r_st <= mbab_pkg::ST_OUT;
                        end else begin
                            r_st  <= mbab_pkg::ST_NEXT;
                            r_dwx <= r_xinc ? r_dwx + LW'(8) : r_dwx - LW'(8);
                            r_swx <= r_xinc ? r_swx + LW'(8) : r_swx - LW'(8);
                            r_dy  <= r_dy1;
                            r_sy  <= r_sy1;
                        end
                    end else begin
                        r_st <= mbab_pkg::ST_NEXT;
                        r_dy <= r_yinc ? r_dy + LW'(1) : r_dy - LW'(1);
                        r_sy <= r_yinc ? r_sy + LW'(1) : r_sy - LW'(1);
                    end
                end
                mbab_pkg::ST_OUT: r_st <= mbab_pkg::ST_IDLE;
                default: r_st <= mbab_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blit_q <= 1'b0;
        end else if (w_accept) begin
            r_blit_q <= i_in_word.action == mbab_pkg::ACT_BLIT;
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != mbab_pkg::ST_IDLE) |-> o_in_stall)
        else $error("input open while busy");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st))
        else $error("state not one-hot");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == mbab_pkg::ST_OUT) |=> o_out_valid)
        else $error("result lost");
endmodule
